// ===== hdl/dq_pkg.sv =====
// Shared types and constants for the bounded deque with search.
package dq_pkg;

  localparam int DATA_W       = 32;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int FILL_W       = 5;
  localparam int CAPACITY_DEF = 16;
  localparam int SCAN_GRP     = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_SEARCH     = 3'd4
  } mode_t;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic take_left;   // shift toward the back (push front)
    logic take_right;  // shift toward the front (pop front)
    logic load_back;   // write the cell sitting at the fill count (push back)
  } cell_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [DATA_W-1:0]   removed;
    logic [FILL_W-1:0]   fill;
  } res_t;

endpackage

// ===== hdl/dq_cell.sv =====
// One storage cell of the deque chain: shift, load, compare and tail select.
module dq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                          clk,
  input  dq_pkg::cell_cmd_t             cmd,
  input  logic [CW-1:0]                 count,
  input  logic signed [dq_pkg::DATA_W-1:0] value,
  input  logic signed [dq_pkg::DATA_W-1:0] left_data,
  input  logic signed [dq_pkg::DATA_W-1:0] right_data,
  input  logic signed [dq_pkg::DATA_W-1:0] key,
  output logic signed [dq_pkg::DATA_W-1:0] data,
  output logic                          hit,
  output logic [dq_pkg::DATA_W-1:0]     tail_data
);

  logic signed [dq_pkg::DATA_W-1:0] data_r;
  logic signed [dq_pkg::DATA_W-1:0] data_nxt;
  logic                             occ;
  logic                             is_tail;
  logic                             is_slot;

  assign occ     = CW'(IDX) < count;
  assign is_tail = CW'(IDX + 1) == count;
  assign is_slot = CW'(IDX) == count;

  always_comb begin
    data_nxt = data_r;
    if (cmd.load_back && is_slot) begin
      data_nxt = value;
    end else if (cmd.take_left) begin
      data_nxt = left_data;
    end else if (cmd.take_right) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign hit       = occ && (data_r == key);
  assign tail_data = is_tail ? data_r : '0;

endmodule

// ===== hdl/dq_scan.sv =====
// Folds the cell match bits and tail data, one group of cells per cycle.
module dq_scan #(
  parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [CAPACITY-1:0]                    hits,
  input  logic [CAPACITY-1:0][dq_pkg::DATA_W-1:0] tails,
  output logic                                   busy,
  output logic                                   done,
  output logic                                   found,
  output logic [dq_pkg::DATA_W-1:0]              data
);

  localparam int GRP  = dq_pkg::SCAN_GRP;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PADN = NGRP * GRP;

  logic [PADN-1:0]                    hits_pad;
  logic [PADN-1:0][dq_pkg::DATA_W-1:0] tails_pad;
  logic [GRP-1:0]                     grp_hits;
  logic [GRP-1:0][dq_pkg::DATA_W-1:0] grp_tails;
  logic [dq_pkg::DATA_W-1:0]          grp_data;
  logic                               last;

  logic                      busy_r, busy_nxt;
  logic [GW-1:0]             grp_r, grp_nxt;
  logic                      found_r, found_nxt;
  logic [dq_pkg::DATA_W-1:0] data_r, data_nxt;

  always_comb begin
    hits_pad  = '0;
    tails_pad = '0;
    hits_pad[CAPACITY-1:0]  = hits;
    tails_pad[CAPACITY-1:0] = tails;
  end

  assign grp_hits  = hits_pad[grp_r * GRP +: GRP];
  assign grp_tails = tails_pad[grp_r * GRP +: GRP];

  always_comb begin
    grp_data = '0;
    for (int i = 0; i < GRP; i++) begin
      grp_data = grp_data | grp_tails[i];
    end
  end

  assign last = grp_r == GW'(NGRP - 1);

  always_comb begin
    busy_nxt  = busy_r;
    grp_nxt   = grp_r;
    found_nxt = found_r;
    data_nxt  = data_r;
    if (start) begin
      busy_nxt  = 1'b1;
      grp_nxt   = '0;
      found_nxt = 1'b0;
      data_nxt  = '0;
    end else if (busy_r) begin
      found_nxt = found_r | (|grp_hits);
      data_nxt  = data_r | grp_data;
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        grp_nxt = grp_r + GW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      grp_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      grp_r  <= grp_nxt;
    end
    found_r <= found_nxt;
    data_r  <= data_nxt;
  end

  assign busy  = busy_r;
  assign done  = busy_r && last;
  assign found = found_r | (|grp_hits);
  assign data  = data_r | grp_data;

endmodule

// ===== hdl/bounded_deque_with_search.sv =====
// Top level of the bounded deque with search: cell chain, scan unit, result buffer.
//
//   channel  direction  ports                                          handshake
//   in       input      in_mode, in_value                              in_valid / in_stall
//   out      output     out_status, out_found, out_removed_value,      out_valid / out_stall
//                       out_fill_count
//
// Push front, push back, pop front, pop back of an empty store and unused modes
// form their result in the cycle they are accepted.
// Search and pop back of a nonempty store start the scan unit, which folds the match
// bits and tail data of 32 cells per cycle; input stalls while it is busy.
// Reset clears the fill count and the control state; the cells need no clearing.
// A result waits in the output register; one more result parks in a skid register,
// so a stalled output blocks input only once both are full.
module bounded_deque_with_search #(
  parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [dq_pkg::MODE_W-1:0]              in_mode,
  input  logic signed [dq_pkg::DATA_W-1:0]       in_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [dq_pkg::STATUS_W-1:0]            out_status,
  output logic                                   out_found,
  output logic signed [dq_pkg::DATA_W-1:0]       out_removed_value,
  output logic [dq_pkg::FILL_W-1:0]              out_fill_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic signed [dq_pkg::DATA_W-1:0] key_r, key_nxt;
  logic          pop_back_r, pop_back_nxt;

  logic          accept;
  logic          full;
  logic          empty;
  dq_pkg::cell_cmd_t cmd;

  logic signed [dq_pkg::DATA_W-1:0]       cell_data [CAPACITY];
  logic [CAPACITY-1:0]                    hits;
  logic [CAPACITY-1:0][dq_pkg::DATA_W-1:0] tails;

  logic                      scan_start;
  logic                      scan_busy;
  logic                      scan_done;
  logic                      scan_found;
  logic [dq_pkg::DATA_W-1:0] scan_data;

  dq_pkg::res_t res;
  logic         res_vld;

  dq_pkg::res_t out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;
  dq_pkg::res_t skid_r, skid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  logic         out_free;

  assign in_stall = scan_busy || skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign full     = count_r == CW'(CAPACITY);
  assign empty    = count_r == '0;

  // Cell chain.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [dq_pkg::DATA_W-1:0] left_d;
    logic signed [dq_pkg::DATA_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid
      assign left_d = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_body
      assign right_d = cell_data[g+1];
    end

    dq_cell #(
      .IDX(g),
      .CW (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .value     (in_value),
      .left_data (left_d),
      .right_data(right_d),
      .key       (key_r),
      .data      (cell_data[g]),
      .hit       (hits[g]),
      .tail_data (tails[g])
    );
  end

  dq_scan #(
    .CAPACITY(CAPACITY)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .start(scan_start),
    .hits (hits),
    .tails(tails),
    .busy (scan_busy),
    .done (scan_done),
    .found(scan_found),
    .data (scan_data)
  );

  always_comb begin
    cmd          = '0;
    count_nxt    = count_r;
    key_nxt      = key_r;
    pop_back_nxt = pop_back_r;
    scan_start   = 1'b0;
    res_vld      = 1'b0;
    res.status   = dq_pkg::ST_DONE;
    res.found    = 1'b0;
    res.removed  = '0;
    if (accept) begin
      case (in_mode)
        dq_pkg::MODE_PUSH_FRONT: begin
          res_vld = 1'b1;
          if (full) begin
            res.status = dq_pkg::ST_FULL;
          end else begin
            cmd.take_left = 1'b1;
            count_nxt     = count_r + CW'(1);
          end
        end
        dq_pkg::MODE_PUSH_BACK: begin
          res_vld = 1'b1;
          if (full) begin
            res.status = dq_pkg::ST_FULL;
          end else begin
            cmd.load_back = 1'b1;
            count_nxt     = count_r + CW'(1);
          end
        end
        dq_pkg::MODE_POP_FRONT: begin
          res_vld = 1'b1;
          if (empty) begin
            res.status = dq_pkg::ST_EMPTY;
          end else begin
            res.removed    = cell_data[0];
            cmd.take_right = 1'b1;
            count_nxt      = count_r - CW'(1);
          end
        end
        dq_pkg::MODE_POP_BACK: begin
          if (empty) begin
            res_vld    = 1'b1;
            res.status = dq_pkg::ST_EMPTY;
          end else begin
            scan_start   = 1'b1;
            pop_back_nxt = 1'b1;
          end
        end
        dq_pkg::MODE_SEARCH: begin
          scan_start   = 1'b1;
          pop_back_nxt = 1'b0;
          key_nxt      = in_value;
        end
        default: begin
          res_vld = 1'b1;
        end
      endcase
    end else if (scan_done) begin
      res_vld = 1'b1;
      if (pop_back_r) begin
        // The tail cell keeps its data; dropping the count frees it.
        res.removed = scan_data;
        count_nxt   = count_r - CW'(1);
      end else begin
        res.found = scan_found;
      end
    end
    res.fill = dq_pkg::FILL_W'(count_nxt);
  end

  // Output register plus one skid entry.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = res_vld;
      end else begin
        out_nxt       = res;
        out_valid_nxt = res_vld;
      end
    end else if (res_vld) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pop_back_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      pop_back_r   <= pop_back_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    key_r  <= key_nxt;
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_found         = out_r.found;
  assign out_removed_value = out_r.removed;
  assign out_fill_count    = out_r.fill;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept || scan_done) |=> $stable(count_r))
    else $error("fill count moved without a transfer or scan completion");

  a_scan_single: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> !accept && !res_vld == 1'b0)
    else $error("scan completion produced no result or overlapped a transfer");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the bounded deque with search: random traffic, shadow model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int DEPTH    = CAPACITY_DEF;
  localparam int POOL_MAX = 24;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
  } deque_req_t;

  typedef enum int { PH_GROW, PH_DRAIN, PH_MIX, PH_SEARCH } traffic_phase_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode   = '0;
  logic [DATA_W-1:0]   in_value  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [DATA_W-1:0]   out_removed_value;
  logic [FILL_W-1:0]   out_fill_count;

  // Shadow copy of the deque contents, entry 0 at the front.
  logic [DATA_W-1:0] shadow_vals [DEPTH];
  int unsigned       shadow_held = 0;

  deque_req_t        pending_reqs[$];
  res_t              expected_results[$];
  logic [DATA_W-1:0] pushed_pool[$];
  int unsigned       err_count = 0;

  bounded_deque_with_search #(.CAPACITY(DEPTH)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_removed_value (out_removed_value),
    .out_fill_count    (out_fill_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("testbench failed");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Update the shadow deque for one accepted request and queue its result.
  task automatic apply_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] val);
    res_t r;
    int   i;
    r = '0;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (shadow_held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_held; i > 0; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[0] = val;
          shadow_held++;
        end
      end
      MODE_PUSH_BACK: begin
        if (shadow_held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_vals[shadow_held] = val;
          shadow_held++;
        end
      end
      MODE_POP_FRONT: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = shadow_vals[0];
          for (i = 0; i < int'(shadow_held) - 1; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_held--;
        end
      end
      MODE_POP_BACK: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_held--;
          r.removed = shadow_vals[shadow_held];
        end
      end
      MODE_SEARCH: begin
        for (i = 0; i < int'(shadow_held); i++)
          if (shadow_vals[i] == val) r.found = 1'b1;
      end
      default: ;
    endcase
    r.fill = shadow_held[FILL_W-1:0];
    expected_results.push_back(r);
  endtask

  // Mix of pool hits, extremes, small values (for duplicates) and full-range noise.
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25 && pushed_pool.size() != 0)
      return pushed_pool[$urandom_range(0, pushed_pool.size() - 1)];
    if (sel < 35) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        3: return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end
    if (sel < 55) return DATA_W'($signed($urandom_range(0, 7)) - 3);
    return $urandom;
  endfunction

  task automatic add_req(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] val);
    deque_req_t q;
    q.mode  = mode;
    q.value = val;
    pending_reqs.push_back(q);
    if (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK) begin
      pushed_pool.push_back(val);
      if (pushed_pool.size() > POOL_MAX) void'(pushed_pool.pop_front());
    end
  endtask

  task automatic add_search();
    if (pushed_pool.size() != 0 && $urandom_range(0, 1) == 1)
      add_req(MODE_SEARCH, pushed_pool[$urandom_range(0, pushed_pool.size() - 1)]);
    else
      add_req(MODE_SEARCH, pick_value());
  endtask

  task automatic build_stimulus();
    traffic_phase_t phase;
    int             seg_left;
    int unsigned    roll;
    int             n;
    // Empty-store corner cases and unused modes, then extremes pushed at both ends and searched.
    add_req(MODE_POP_FRONT, $urandom);
    add_req(MODE_POP_BACK, $urandom);
    add_req(MODE_SEARCH, 32'h0000_0000);
    add_req(3'd5, $urandom);
    add_req(3'd6, $urandom);
    add_req(3'd7, $urandom);
    add_req(MODE_PUSH_FRONT, 32'h8000_0000);
    add_req(MODE_PUSH_BACK, 32'h7fff_ffff);
    add_req(MODE_SEARCH, 32'h8000_0000);
    add_req(MODE_SEARCH, 32'h0000_0000);
    // Fill to capacity, push into a full store from both ends, then pop from both ends.
    for (n = 0; n < DEPTH - 2; n++)
      add_req(n[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT, $urandom);
    add_req(MODE_PUSH_FRONT, 32'hffff_ffff);
    add_req(MODE_PUSH_BACK, 32'h0000_0000);
    add_req(MODE_POP_FRONT, $urandom);
    add_req(MODE_POP_BACK, $urandom);

    seg_left = 0;
    phase    = PH_MIX;
    for (n = 0; n < 1200; n++) begin
      if (seg_left == 0) begin
        phase    = traffic_phase_t'($urandom_range(0, 3));
        seg_left = $urandom_range(10, 50);
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        add_req(MODE_W'($urandom_range(5, 7)), $urandom);
        continue;
      end
      case (phase)
        PH_GROW:   roll = (roll < 75) ? 0 : (roll < 90) ? 2 : 1;
        PH_DRAIN:  roll = (roll < 75) ? 1 : (roll < 90) ? 2 : 0;
        PH_SEARCH: roll = (roll < 60) ? 2 : (roll < 80) ? 0 : 1;
        default:   roll = $urandom_range(0, 2);
      endcase
      case (roll)
        0: add_req($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
        1: add_req($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT, $urandom);
        default: add_search();
      endcase
    end
  endtask

  // Sender: bursts of transfers separated by random idle gaps.
  int         gap_left   = 0;
  int         burst_left = 0;
  deque_req_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (in_valid && !in_stall) apply_request(in_mode, in_value);
      if (in_valid && in_stall) begin
        // hold the stalled payload
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_mode  <= next_req.mode;
        in_value <= next_req.value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches between free-running, random and long holds.
  int unsigned stall_pat  = 0;
  int unsigned pat_left   = 0;
  int unsigned stall_cnt  = 0;
  res_t        want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          flag_error("result transfer with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(out_status), 32'(want.status));
          check_field("found", 32'(out_found), 32'(want.found));
          check_field("removed_value", out_removed_value, want.removed);
          check_field("fill_count", 32'(out_fill_count), 32'(want.fill));
        end
      end
      if (pat_left == 0) begin
        stall_pat = $urandom_range(0, 4);
        pat_left  = $urandom_range(30, 200);
      end else begin
        pat_left--;
      end
      stall_cnt++;
      case (stall_pat)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        3: out_stall <= (stall_cnt % 5 < 2);
        default: out_stall <= (stall_cnt % 24 < 18);
      endcase
    end
  end

  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== bounded_deque_with_search.f =====
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/dq_scan.sv
hdl/bounded_deque_with_search.sv
tb/sv/testbench.sv
